// File: rtl/lpd_pkg.sv
// Package for the length-prefix deframer: shared types, register indexes and codes.
// Used by lpd_core and length_prefix_deframer_unit; depends on nothing else.
`timescale 1ns / 1ps

package lpd_pkg;

    // Field widths of the stream items.
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned LEN_W  = 31;
    localparam int unsigned ERR_W  = 2;
    localparam int unsigned ACC_W  = 64;

    // APB register map: register index is paddr[4:2].
    localparam int unsigned PADDR_W = 5;
    localparam int unsigned PDATA_W = 32;
    localparam logic [2:0] REG_SIZE_FIELD_LOG2       = 3'd0;
    localparam logic [2:0] REG_SIZE_FIELD_SIGNED     = 3'd1;
    localparam logic [2:0] REG_SIZE_COUNTS_FIELD     = 3'd2;
    localparam logic [2:0] REG_KEEP_FIELD_IN_MESSAGE = 3'd3;
    localparam logic [2:0] REG_MAX_BODY_BYTES        = 3'd4;

    // Register reset values.
    localparam logic [1:0]       RST_SIZE_FIELD_LOG2 = 2'd2;
    localparam logic [LEN_W-1:0] RST_MAX_BODY_BYTES  = 31'd1048576;

    // Error codes reported on the detecting byte.
    localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
    localparam logic [ERR_W-1:0] ERR_BAD_SIZE = 2'd1;
    localparam logic [ERR_W-1:0] ERR_TOO_BIG  = 2'd2;

    // Saturated reported length.
    localparam logic [LEN_W-1:0] LEN_MAX = '1;

    // Configuration register set.
    typedef struct packed {
        logic [1:0]       size_field_log2;
        logic             size_field_signed;
        logic             size_counts_field;
        logic             keep_field_in_message;
        logic [LEN_W-1:0] max_body_bytes;
    } t_cfg;

    // One input request.
    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] stream_byte;
    } t_item;

    // One result request.
    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              in_message;
        logic              message_start;
        logic              message_end;
        logic [LEN_W-1:0]  message_length;
        logic [ERR_W-1:0]  error_code;
        logic              stream_invalid;
    } t_result;

endpackage

// File: rtl/lpd_core.sv
// Deframer state and per-byte next-state/result logic of the length-prefix deframer.
// Depends on lpd_pkg; instantiated by length_prefix_deframer_unit.
`timescale 1ns / 1ps

module lpd_core
    import lpd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_adv,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_BODY,
        PH_INVALID
    } t_phase;

    t_phase           r_phase,   n_phase;
    logic [3:0]       r_hdr_cnt, n_hdr_cnt;
    logic [ACC_W-1:0] r_acc,     n_acc;
    logic [LEN_W-1:0] r_rem,     n_rem;
    logic [LEN_W-1:0] r_rep,     n_rep;

    // Size field geometry from the current configuration.
    logic [3:0]  fld_len;
    logic [31:0] fld_len32;
    logic [31:0] fld_sub;
    logic [31:0] fld_add;
    logic [31:0] limit;

    assign fld_len   = 4'd1 << i_cfg.size_field_log2;
    assign fld_len32 = {28'd0, fld_len};
    assign fld_sub   = i_cfg.size_counts_field ? fld_len32 : 32'd0;
    assign fld_add   = i_cfg.keep_field_in_message ? fld_len32 : 32'd0;
    assign limit     = {1'b0, i_cfg.max_body_bytes} + fld_sub;

    // Header gathering: shift the byte in and take the low field bytes as the size.
    logic [ACC_W-1:0] acc_shift;
    logic [3:0]       hdr_inc;
    logic [ACC_W-1:0] size;
    logic             size_neg;

    assign acc_shift = {r_acc[ACC_W-BYTE_W-1:0], i_item.stream_byte};
    assign hdr_inc   = r_hdr_cnt + 4'd1;

    always_comb begin
        case (i_cfg.size_field_log2)
            2'd0: begin
                size     = {56'd0, acc_shift[7:0]};
                size_neg = acc_shift[7];
            end
            2'd1: begin
                size     = {48'd0, acc_shift[15:0]};
                size_neg = acc_shift[15];
            end
            2'd2: begin
                size     = {32'd0, acc_shift[31:0]};
                size_neg = acc_shift[31];
            end
            default: begin
                size     = acc_shift;
                size_neg = acc_shift[63];
            end
        endcase
    end

    // Size checks and derived lengths.
    logic        size_hi_nz;
    logic        size_under;
    logic        size_over;
    logic        err_bad;
    logic [31:0] body32;
    logic [31:0] rep32;
    logic [LEN_W-1:0] rep_sat;

    assign size_hi_nz = |size[ACC_W-1:32];
    assign size_under = (size[ACC_W-1:4] == '0) && (size[3:0] < fld_len);
    assign size_over  = size_hi_nz || (size[31:0] > limit);
    assign err_bad    = (i_cfg.size_field_signed && size_neg) ||
                        (i_cfg.size_counts_field && size_under);
    assign body32     = size[31:0] - fld_sub;
    assign rep32      = body32 + fld_add;
    assign rep_sat    = rep32[31] ? LEN_MAX : rep32[LEN_W-1:0];

    logic [LEN_W-1:0] rem_dec;
    assign rem_dec = r_rem - 31'd1;

    // Next state and result for the request at the head of the input register.
    always_comb begin
        n_phase   = r_phase;
        n_hdr_cnt = r_hdr_cnt;
        n_acc     = r_acc;
        n_rem     = r_rem;
        n_rep     = r_rep;
        o_result  = '0;
        o_result.out_byte = i_item.stream_byte;

        if (i_item.kind) begin
            // Resync clears everything and reports nothing.
            o_result  = '0;
            n_phase   = PH_HEADER;
            n_hdr_cnt = '0;
            n_acc     = '0;
            n_rem     = '0;
            n_rep     = '0;
        end else begin
            case (r_phase)
                PH_INVALID: begin
                    o_result.stream_invalid = 1'b1;
                end
                PH_BODY: begin
                    o_result.in_message = 1'b1;
                    if (r_hdr_cnt != 4'd0) begin
                        o_result.message_start = !i_cfg.keep_field_in_message;
                        n_hdr_cnt = '0;
                    end
                    n_rem = rem_dec;
                    if (rem_dec == '0) begin
                        o_result.message_end    = 1'b1;
                        o_result.message_length = r_rep;
                        n_phase   = PH_HEADER;
                        n_hdr_cnt = '0;
                        n_acc     = '0;
                        n_rep     = '0;
                    end
                end
                PH_HEADER: begin
                    n_acc     = acc_shift;
                    n_hdr_cnt = hdr_inc;
                    if (hdr_inc < fld_len) begin
                        o_result.in_message    = i_cfg.keep_field_in_message;
                        o_result.message_start = i_cfg.keep_field_in_message &&
                                                 (r_hdr_cnt == 4'd0);
                    end else if (err_bad || size_over) begin
                        o_result.error_code     = err_bad ? ERR_BAD_SIZE : ERR_TOO_BIG;
                        o_result.stream_invalid = 1'b1;
                        n_phase   = PH_INVALID;
                        n_hdr_cnt = '0;
                        n_acc     = '0;
                        n_rem     = '0;
                        n_rep     = '0;
                    end else begin
                        o_result.in_message    = i_cfg.keep_field_in_message;
                        o_result.message_start = i_cfg.keep_field_in_message &&
                                                 (r_hdr_cnt == 4'd0);
                        if (body32 == 32'd0) begin
                            // Empty body ends the message on the last header byte.
                            o_result.message_end    = 1'b1;
                            o_result.message_length = rep_sat;
                            n_phase   = PH_HEADER;
                            n_hdr_cnt = '0;
                            n_acc     = '0;
                            n_rem     = '0;
                            n_rep     = '0;
                        end else begin
                            n_phase   = PH_BODY;
                            n_rem     = body32[LEN_W-1:0];
                            n_rep     = rep_sat;
                            n_hdr_cnt = 4'd1;
                            n_acc     = '0;
                        end
                    end
                end
                default: begin
                    n_phase = PH_HEADER;
                end
            endcase
        end
    end

    // State update, one step per processed request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HEADER;
            r_hdr_cnt <= '0;
            r_acc     <= '0;
            r_rem     <= '0;
            r_rep     <= '0;
        end else if (i_adv) begin
            r_phase   <= n_phase;
            r_hdr_cnt <= n_hdr_cnt;
            r_acc     <= n_acc;
            r_rem     <= n_rem;
            r_rep     <= n_rep;
        end
    end

    // A processed resync always returns the deframer to an empty header.
    a_resync_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && i_item.kind) |=> (r_phase == PH_HEADER && r_hdr_cnt == 4'd0))
        else $error("resync did not clear the deframer state");

    // A body in progress always has bytes left to take.
    a_body_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_BODY) |-> (r_rem != '0))
        else $error("body phase with no bytes remaining");

    // The invalid state is left only through a resync.
    a_invalid_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && !i_item.kind && r_phase == PH_INVALID) |=> (r_phase == PH_INVALID))
        else $error("invalid stream left without resync");

    // An error byte is never part of a message.
    a_error_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.error_code != ERR_NONE) |->
            (o_result.stream_invalid && !o_result.in_message && !o_result.message_end))
        else $error("error result carries message flags");

endmodule

// File: rtl/length_prefix_deframer_unit.sv
// Top level of the length-prefix deframer: stream ports, APB registers and pipeline registers.
// Depends on lpd_pkg and lpd_core.
`timescale 1ns / 1ps

// The deframer takes one stream request per clock and returns one result request for each:
// the per-byte header/body step runs on the byte in the input register against the deframer
// state, and the result is then held in the output register. The sustained rate is one byte
// per cycle, set by the single state update per byte; the output register lets a new byte
// enter while a result still waits, so only a stalled output with a full input register
// holds back the input. A resync request (tuser high) clears any partial message and a
// sticky invalid state. Registers are to be written through APB while the stream is idle
// (the block itself does not enforce this) and take effect on the next byte, even mid-header.

module length_prefix_deframer_unit
    import lpd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Input stream
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  logic [7:0]         i_s_tdata,   // [7:0] stream_byte
    input  logic               i_s_tuser,   // [0] kind (1 = resync)
    // Result stream
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output logic [39:0]        o_m_tdata,   // [7:0] out_byte, [38:8] message_length, [39] zero
    output logic [4:0]         o_m_tuser,   // [0] in_message, [1] message_start,
                                            // [3:2] error_code, [4] stream_invalid
    output logic               o_m_tlast,   // message_end
    // APB configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    // Configuration registers.
    t_cfg       r_cfg;
    logic       cfg_wr;
    logic [2:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[PADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.size_field_log2       <= RST_SIZE_FIELD_LOG2;
            r_cfg.size_field_signed     <= 1'b0;
            r_cfg.size_counts_field     <= 1'b0;
            r_cfg.keep_field_in_message <= 1'b0;
            r_cfg.max_body_bytes        <= RST_MAX_BODY_BYTES;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_SIZE_FIELD_LOG2:       r_cfg.size_field_log2       <= pwdata[1:0];
                REG_SIZE_FIELD_SIGNED:     r_cfg.size_field_signed     <= pwdata[0];
                REG_SIZE_COUNTS_FIELD:     r_cfg.size_counts_field     <= pwdata[0];
                REG_KEEP_FIELD_IN_MESSAGE: r_cfg.keep_field_in_message <= pwdata[0];
                REG_MAX_BODY_BYTES:        r_cfg.max_body_bytes        <= pwdata[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (cfg_idx)
            REG_SIZE_FIELD_LOG2:       prdata = {30'd0, r_cfg.size_field_log2};
            REG_SIZE_FIELD_SIGNED:     prdata = {31'd0, r_cfg.size_field_signed};
            REG_SIZE_COUNTS_FIELD:     prdata = {31'd0, r_cfg.size_counts_field};
            REG_KEEP_FIELD_IN_MESSAGE: prdata = {31'd0, r_cfg.keep_field_in_message};
            REG_MAX_BODY_BYTES:        prdata = {1'b0, r_cfg.max_body_bytes};
            default:                   prdata = '0;
        endcase
    end

    // Pipeline handshake: the input register advances into the output register
    // whenever the output register is empty or being drained.
    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    t_result step_res;
    logic    adv;

    assign adv        = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in.kind        <= i_s_tuser;
            r_in.stream_byte <= i_s_tdata;
        end
        if (adv) begin
            r_out <= step_res;
        end
    end

    // Per-byte deframing step and its state.
    lpd_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_item   (r_in),
        .i_cfg    (r_cfg),
        .o_result (step_res)
    );

    // Result stream packing.
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out.message_length, r_out.out_byte};
    assign o_m_tuser  = {r_out.stream_invalid, r_out.error_code,
                         r_out.message_start, r_out.in_message};
    assign o_m_tlast  = r_out.message_end;

endmodule
